/* src/mxp_pkg.sv */
// ----------------------------------------------------------------------------
// mxp_pkg: shared types for the modular exponentiation block
// Command and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package mxp_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // take a new item: capture base and exponent
    logic step;         // advance both multiplier lanes by one bit
    logic reduce_mode;  // lane B multiplies by one (base reduction pass)
    logic red_end;      // close the reduction pass: base power from lane B
    logic bit_end;      // close one exponent bit: square, conditional multiply
    logic out_load;     // move the finished value into the output register
  } mxp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic exp_zero;       // exponent register is zero
    logic exp_high_zero;  // exponent register holds no set bit above bit 0
  } mxp_status_t;

endpackage

/* src/mxp_lane.sv */
// ----------------------------------------------------------------------------
// mxp_lane: bit-serial modular multiplier lane
// Interleaved double-and-add: one multiplier bit per step, MSB first,
// keeping the partial result below the modulus.
// ----------------------------------------------------------------------------
module mxp_lane #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         clr,
  input  logic         en,
  input  logic [W-1:0] mcand,
  input  logic         mbit,
  input  logic [W-1:0] m,
  output logic [W-1:0] r
);

  logic [W:0]   dbl;
  logic [W-1:0] dbl_red;
  logic [W:0]   sum;
  logic [W-1:0] sum_red;
  logic [W-1:0] r_next;

  // Double the partial result and reduce once
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
  end

  // Add the multiplicand when the multiplier bit is set, reduce once
  always_comb begin
    sum     = {1'b0, dbl_red} + {1'b0, mcand};
    sum_red = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
    r_next  = mbit ? sum_red : dbl_red;
  end

  // Hold, clear or advance the partial result
  always_ff @(posedge clk) begin
    if (clr) begin
      r <= '0;
    end else if (en) begin
      r <= r_next;
    end
  end

endmodule

/* src/mxp_dp.sv */
// ----------------------------------------------------------------------------
// mxp_dp: datapath of the modular exponentiation block
// Modulus register, exponent shifter, base power and accumulator registers,
// two multiplier lanes (multiply and square) and the output register.
// ----------------------------------------------------------------------------
module mxp_dp #(
  parameter int W = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mxp_pkg::mxp_cmd_t    cmd,
  output mxp_pkg::mxp_status_t status,
  input  logic                 cfg_we,
  input  logic [W-1:0]         cfg_modulus,
  input  logic [W-1:0]         base_value,
  input  logic [W-1:0]         exponent_value,
  output logic [W-1:0]         power_result
);

  localparam logic [W-1:0] ONE = W'(1);

  logic [W-1:0] modulus;
  logic [W-1:0] m_eff;
  logic [W-1:0] mbits;
  logic [W-1:0] expo;
  logic [W-1:0] pw;
  logic [W-1:0] acc;
  logic         exp_was_zero;
  logic [W-1:0] ra;
  logic [W-1:0] rb;
  logic [W-1:0] mcand_b;
  logic         lane_clr;

  // Modulus register; zero behaves as one
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(2);
    end else if (cfg_we) begin
      modulus <= cfg_modulus;
    end
  end

  assign m_eff = (modulus == '0) ? ONE : modulus;

  // Lane A forms acc * pw, lane B forms pw * pw (or base * 1 when reducing)
  assign mcand_b  = cmd.reduce_mode ? ONE : pw;
  assign lane_clr = cmd.load | cmd.red_end | cmd.bit_end;

  mxp_lane #(.W(W)) u_lane_a (
    .clk   (clk),
    .clr   (lane_clr),
    .en    (cmd.step),
    .mcand (acc),
    .mbit  (mbits[W-1]),
    .m     (m_eff),
    .r     (ra)
  );

  mxp_lane #(.W(W)) u_lane_b (
    .clk   (clk),
    .clr   (lane_clr),
    .en    (cmd.step),
    .mcand (mcand_b),
    .mbit  (mbits[W-1]),
    .m     (m_eff),
    .r     (rb)
  );

  // Capture the item, shift multiplier bits, update powers per exponent bit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mbits        <= base_value;
      expo         <= exponent_value;
      exp_was_zero <= (exponent_value == '0);
      acc          <= (m_eff == ONE) ? '0 : ONE;
    end else if (cmd.step) begin
      mbits <= {mbits[W-2:0], 1'b0};
    end else if (cmd.red_end) begin
      pw    <= rb;
      mbits <= rb;
    end else if (cmd.bit_end) begin
      pw    <= rb;
      mbits <= rb;
      expo  <= {1'b0, expo[W-1:1]};
      if (expo[0]) begin
        acc <= ra;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      power_result <= exp_was_zero ? ONE : acc;
    end
  end

  assign status.exp_zero      = (expo == '0);
  assign status.exp_high_zero = (expo[W-1:1] == '0);

endmodule

/* src/mxp_ctrl.sv */
// ----------------------------------------------------------------------------
// mxp_ctrl: controller of the modular exponentiation block
// Sequences the base reduction pass and one multiply pass per exponent bit,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mxp_ctrl #(
  parameter int W = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mxp_pkg::mxp_cmd_t    cmd,
  input  mxp_pkg::mxp_status_t status
);

  localparam int CW = $clog2(W);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_REDEND = 3'd2;
  localparam logic [2:0] S_MULT   = 3'd3;
  localparam logic [2:0] S_MULEND = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [CW-1:0] cnt;
  logic          out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.step        = 1'b1;
        cmd.reduce_mode = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_REDEND;
        end
      end
      S_REDEND: begin
        cmd.red_end = 1'b1;
        state_next  = status.exp_zero ? S_DONE : S_MULT;
      end
      S_MULT: begin
        cmd.step = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_MULEND;
        end
      end
      S_MULEND: begin
        cmd.bit_end = 1'b1;
        state_next  = status.exp_high_zero ? S_DONE : S_MULT;
      end
      S_DONE: begin
        cmd.out_load = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        cnt <= (cnt == CNT_LAST) ? '0 : cnt + CW'(1);
      end
    end
  end

  // Output valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while holding an item");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt == '0))
    else $error("bit counter not at zero while idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_REDUCE))
    else $error("accepted item did not start the reduction pass");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a load");

endmodule

/* src/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation: base to the exponent modulo a configured modulus
// Right-to-left square-and-multiply on two bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries base_value and exponent_value;
//   an item is taken when in_valid is high and in_stall low. One item is
//   worked on at a time, so in_stall stays high until the item is finished.
//   Output channel (out_valid / out_stall) carries power_result, one result
//   per item. The result sits in an output register: while the receiver
//   stalls it holds, and the block can already take and work on the next item.
//   Configuration channel (cfg_valid / cfg_ready) writes the modulus; ready is
//   always high. Write it only while the block is idle. Zero acts as one.
// Sequence: an accepted item runs the base reduction pass (S_REDUCE, then
// S_REDEND), then one multiply pass (S_MULT, then S_MULEND) per exponent bit
// up to the highest set bit (none for exponent zero), then S_DONE, which waits
// until the output register is free, loads it and returns to idle; out_valid
// rises in the same cycle as the block is idle again. The multiplier lanes take
// one multiplier bit per cycle, and each pass ends in its closing state.
// Reset (rst, synchronous) empties the output register, returns to idle and
// sets the modulus to 2.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [OPERAND_WIDTH-1:0] modulus,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_WIDTH-1:0] base_value,
  input  logic [OPERAND_WIDTH-1:0] exponent_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OPERAND_WIDTH-1:0] power_result
);

  mxp_pkg::mxp_cmd_t    cmd;
  mxp_pkg::mxp_status_t status;

  assign cfg_ready = 1'b1;

  mxp_ctrl #(.W(OPERAND_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  mxp_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_modulus    (modulus),
    .base_value     (base_value),
    .exponent_value (exponent_value),
    .power_result   (power_result)
  );

endmodule
